// ===== sv/usph_pkg.sv =====
`default_nettype none
package usph_pkg;

    localparam int MAX_SEGMENTS  = 1024;
    localparam int MAX_RINGS     = 1024;
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int CFG_W         = 11;
    localparam int IDX_W         = 20;
    localparam int DIV_STEPS     = 16;
    localparam int CORD_W        = 34;
    localparam int FIFO_DEPTH    = 32;
    localparam int FIFO_AW       = 5;
    localparam int CNT_W         = FIFO_AW + 1;
    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

    // register index on the configuration port
    localparam logic REG_SEGMENTS = 1'b0;
    localparam logic REG_RINGS    = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_tri;

    // per-item control and payload that rides along the pipeline
    typedef struct packed {
        logic             valid;
        logic             reject;
        logic             has_vtx;
        logic [1:0]       ntri;
        logic [IDX_W-1:0] vidx;
        t_tri             t1;
        t_tri             t2;
        logic [15:0]      tu;
        logic [15:0]      tv;
    } t_side;

    typedef struct packed {
        logic [11:0] rem;
        logic [15:0] w;
    } t_div_lane;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
        logic                     neg;
    } t_cord_lane;

    typedef struct packed {
        logic               reject;
        logic               has_vtx;
        logic [1:0]         ntri;
        logic [IDX_W-1:0]   vidx;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [15:0]        tu;
        logic [15:0]        tv;
        t_tri               t1;
        t_tri               t2;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic [IDX_W-1:0]   vidx;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [15:0]        tu;
        logic [15:0]        tv;
        logic [IDX_W-1:0]   ca;
        logic [IDX_W-1:0]   cb;
        logic [IDX_W-1:0]   cc;
    } t_result;

    // arctangent of 2^-k, full turn is 2^32
    function automatic logic [31:0] atan_val(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/usph_div_cell.sv =====
`default_nettype none
module usph_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [11:0]        i_du,
    input  wire logic [11:0]        i_dv,
    input  wire usph_pkg::t_side     i_side,
    input  wire usph_pkg::t_div_lane i_u,
    input  wire usph_pkg::t_div_lane i_v,
    output usph_pkg::t_side          o_side,
    output usph_pkg::t_div_lane      o_u,
    output usph_pkg::t_div_lane      o_v
);
    usph_pkg::t_side     r_side;
    usph_pkg::t_div_lane r_u;
    usph_pkg::t_div_lane r_v;
    usph_pkg::t_div_lane n_u;
    usph_pkg::t_div_lane n_v;
    logic [12:0]         t_u;
    logic [12:0]         t_v;
    logic                ge_u;
    logic                ge_v;

    // one restoring step per lane: shift in a numerator bit, try subtract
    always_comb begin
        t_u    = {i_u.rem, i_u.w[15]};
        t_v    = {i_v.rem, i_v.w[15]};
        ge_u   = t_u >= {1'b0, i_du};
        ge_v   = t_v >= {1'b0, i_dv};
        n_u.rem = ge_u ? 12'(t_u - {1'b0, i_du}) : t_u[11:0];
        n_v.rem = ge_v ? 12'(t_v - {1'b0, i_dv}) : t_v[11:0];
        n_u.w   = {i_u.w[14:0], ge_u};
        n_v.w   = {i_v.w[14:0], ge_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
    end

    assign o_side = r_side;
    assign o_u    = r_u;
    assign o_v    = r_v;
endmodule
`default_nettype wire

// ===== sv/usph_cordic_cell.sv =====
`default_nettype none
module usph_cordic_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [4:0]          i_stage,
    input  wire usph_pkg::t_side      i_side,
    input  wire usph_pkg::t_cord_lane i_u,
    input  wire usph_pkg::t_cord_lane i_v,
    output usph_pkg::t_side           o_side,
    output usph_pkg::t_cord_lane      o_u,
    output usph_pkg::t_cord_lane      o_v
);
    usph_pkg::t_side      r_side;
    usph_pkg::t_cord_lane r_u;
    usph_pkg::t_cord_lane r_v;
    usph_pkg::t_cord_lane n_u;
    usph_pkg::t_cord_lane n_v;
    logic signed [usph_pkg::CORD_W-1:0] at;

    function automatic usph_pkg::t_cord_lane rot(
        input usph_pkg::t_cord_lane l,
        input logic [4:0] k,
        input logic signed [usph_pkg::CORD_W-1:0] a
    );
        usph_pkg::t_cord_lane r;
        logic signed [usph_pkg::CORD_W-1:0] dx;
        logic signed [usph_pkg::CORD_W-1:0] dy;
        dx    = l.y >>> k;
        dy    = l.x >>> k;
        r.neg = l.neg;
        if (!l.z[usph_pkg::CORD_W-1]) begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - a;
        end else begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + a;
        end
        return r;
    endfunction

    // one micro-rotation on both angle lanes
    always_comb begin
        at  = signed'({2'b00, usph_pkg::atan_val(i_stage)});
        n_u = rot(i_u, i_stage, at);
        n_v = rot(i_v, i_stage, at);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
    end

    assign o_side = r_side;
    assign o_u    = r_u;
    assign o_v    = r_v;
endmodule
`default_nettype wire

// ===== sv/usph_emit.sv =====
`default_nettype none
module usph_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_push,
    input  wire usph_pkg::t_item i_item,
    output logic               o_busy,
    output logic               o_valid,
    output usph_pkg::t_result  o_res
);
    localparam int CNT_W = usph_pkg::CNT_W;

    usph_pkg::t_item                r_mem [usph_pkg::FIFO_DEPTH];
    logic [usph_pkg::FIFO_AW-1:0]   r_wr;
    logic [usph_pkg::FIFO_AW-1:0]   r_rd;
    logic [usph_pkg::CNT_W-1:0]     r_fcnt;
    logic [usph_pkg::CNT_W-1:0]     r_count;
    usph_pkg::t_item                r_cur;
    logic                           r_cur_valid;
    logic [1:0]                     r_idx;
    logic                           r_out_valid;
    usph_pkg::t_result              r_out;
    usph_pkg::t_result              n_out;
    logic [1:0]                     ntot;
    logic [1:0]                     sel;
    logic                           is_last;
    logic                           pop;

    // pick the result that the current word gives at this position
    always_comb begin
        ntot    = r_cur.reject ? 2'd1 : 2'(2'(r_cur.has_vtx) + r_cur.ntri);
        sel     = 2'(r_idx + (r_cur.has_vtx ? 2'd0 : 2'd1));
        is_last = (r_idx == 2'(ntot - 2'd1));
        pop     = (r_fcnt != '0) && (!r_cur_valid || is_last);
        n_out   = '0;
        n_out.last = is_last;
        if (r_cur.reject) begin
            n_out.kind = usph_pkg::KIND_REJECT;
            n_out.last = 1'b1;
        end else begin
            unique case (sel)
                2'd0: begin
                    n_out.kind = usph_pkg::KIND_VERTEX;
                    n_out.vidx = r_cur.vidx;
                    n_out.px   = r_cur.px;
                    n_out.py   = r_cur.py;
                    n_out.pz   = r_cur.pz;
                    n_out.tu   = r_cur.tu;
                    n_out.tv   = r_cur.tv;
                end
                2'd1: begin
                    n_out.kind = usph_pkg::KIND_TRI;
                    n_out.ca   = r_cur.t1.a;
                    n_out.cb   = r_cur.t1.b;
                    n_out.cc   = r_cur.t1.c;
                end
                default: begin
                    n_out.kind = usph_pkg::KIND_TRI;
                    n_out.ca   = r_cur.t2.a;
                    n_out.cb   = r_cur.t2.b;
                    n_out.cc   = r_cur.t2.c;
                end
            endcase
        end
    end

    // item queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // queue pointers, credits and current word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_fcnt      <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fcnt  <= r_fcnt + CNT_W'(i_push) - CNT_W'(pop);
            r_count <= r_count + CNT_W'(i_accept) - CNT_W'(pop);
            if (pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (r_cur_valid && is_last) begin
                r_cur_valid <= 1'b0;
            end else if (r_cur_valid) begin
                r_idx <= r_idx + 2'd1;
            end
            r_out_valid <= r_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= r_mem[r_rd];
        end
        r_out <= n_out;
    end

    assign o_busy  = (r_count == CNT_W'(usph_pkg::FIFO_DEPTH));
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(usph_pkg::FIFO_DEPTH))
        else $error("credit count above queue depth");
    a_fifo_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_count)
        else $error("queue holds more words than credits taken");
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == usph_pkg::KIND_REJECT) |-> r_out.last)
        else $error("reject result not marked last");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_fcnt != CNT_W'(usph_pkg::FIFO_DEPTH)) || pop)
        else $error("push into full queue");
endmodule
`default_nettype wire

// ===== sv/uv_sphere_tessellator.sv =====
`default_nettype none
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+-----------------------------------
// command  | in        | start high, busy low          | i_ring, i_segment
// result   | out       | o_valid, one cycle, no stall  | o_kind .. o_corner_c
// config   | in/out    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// a word enters every cycle while fewer than 32 words sit in the pipeline and queue;
// from start to the first result a word passes the entry register, 16 divide cells,
// 16 rotation cells, multiply, round, queue and output register
// results leave at one per cycle, and a word gives 1 to 3 results on the result port
// synchronous reset sets segments and rings to 16 and empties pipeline and queue
module uv_sphere_tessellator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [10:0] i_ring,
    input  wire logic [9:0]  i_segment,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic             o_last_of_item,
    output logic [19:0]      o_vertex_index,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic [15:0]      o_tex_u,
    output logic [15:0]      o_tex_v,
    output logic [19:0]      o_corner_a,
    output logic [19:0]      o_corner_b,
    output logic [19:0]      o_corner_c,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW  = usph_pkg::CORD_W;
    localparam int IW  = usph_pkg::IDX_W;
    localparam int NS  = usph_pkg::CORDIC_STAGES;
    localparam int ND  = usph_pkg::DIV_STEPS;
    localparam int PSH = 60 - usph_pkg::FRAC_BITS;
    localparam int YSH = 30 - usph_pkg::FRAC_BITS;

    logic [10:0] r_segments;
    logic [10:0] r_rings;
    logic [10:0] seg_c;
    logic [10:0] ring_c;
    logic        accept;
    logic        wr_en;

    // configuration registers
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= 11'd16;
            r_rings    <= 11'd16;
        end else if (wr_en) begin
            unique case (paddr[2])
                usph_pkg::REG_SEGMENTS: r_segments <= pwdata[10:0];
                usph_pkg::REG_RINGS:    r_rings    <= pwdata[10:0];
            endcase
        end
    end
    always_comb begin
        unique case (paddr[2])
            usph_pkg::REG_SEGMENTS: prdata = {21'd0, r_segments};
            usph_pkg::REG_RINGS:    prdata = {21'd0, r_rings};
        endcase
    end

    // clamp to supported sizes
    always_comb begin
        if (r_segments < 11'd3) begin
            seg_c = 11'd3;
        end else if (r_segments > 11'(usph_pkg::MAX_SEGMENTS)) begin
            seg_c = 11'(usph_pkg::MAX_SEGMENTS);
        end else begin
            seg_c = r_segments;
        end
        if (r_rings < 11'd2) begin
            ring_c = 11'd2;
        end else if (r_rings > 11'(usph_pkg::MAX_RINGS)) begin
            ring_c = 11'(usph_pkg::MAX_RINGS);
        end else begin
            ring_c = r_rings;
        end
    end

    assign accept = start && !busy;

    // entry stage: range check, ring base index, divide numerators
    logic        r_e_valid;
    logic [10:0] r_e_ring;
    logic [9:0]  r_e_seg;
    logic [9:0]  r_e_nxt;
    logic        r_e_reject;
    logic [IW-1:0] r_e_base;
    logic [27:0] r_e_nu;
    logic [27:0] r_e_nv;
    logic [10:0] rm1;
    logic [21:0] prod_b;

    always_comb begin
        rm1    = i_ring - 11'd1;
        prod_b = 22'(rm1) * 22'(seg_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ring   <= i_ring;
        r_e_seg    <= i_segment;
        r_e_nxt    <= ((11'(i_segment) + 11'd1) == seg_c) ? 10'd0 : 10'(i_segment + 10'd1);
        r_e_reject <= (i_ring > ring_c) || (11'(i_segment) >= seg_c) ||
                      ((i_ring == 11'd0) && (i_segment != 10'd0));
        r_e_base   <= IW'(prod_b + 22'd1);
        r_e_nu     <= {1'b0, i_segment, 17'd0} + 28'(seg_c);
        r_e_nv     <= {1'b0, i_ring, 16'd0} + 28'(ring_c);
    end

    // triangle corners and vertex index
    usph_pkg::t_side     side_e;
    logic [IW-1:0]       prev;
    logic [IW-1:0]       a_i;
    logic [IW-1:0]       b_i;
    logic [IW-1:0]       c_i;
    logic [IW-1:0]       d_i;

    always_comb begin
        prev   = r_e_base - IW'(seg_c);
        a_i    = r_e_base + IW'(r_e_seg);
        b_i    = r_e_base + IW'(r_e_nxt);
        d_i    = prev + IW'(r_e_seg);
        c_i    = prev + IW'(r_e_nxt);
        side_e = '0;
        side_e.valid   = r_e_valid;
        side_e.reject  = r_e_reject;
        side_e.has_vtx = !r_e_reject && !((r_e_ring == ring_c) && (r_e_seg != 10'd0));
        side_e.vidx    = (r_e_ring == 11'd0) ? '0 : a_i;
        if (r_e_reject || r_e_ring == 11'd0) begin
            side_e.ntri = 2'd0;
        end else if (r_e_ring == 11'd1) begin
            side_e.ntri = 2'd1;
            side_e.t1   = '{a: '0, b: a_i, c: b_i};
        end else if (r_e_ring < ring_c) begin
            side_e.ntri = 2'd2;
            side_e.t1   = '{a: a_i, b: b_i, c: d_i};
            side_e.t2   = '{a: d_i, b: c_i, c: b_i};
        end else begin
            side_e.ntri = 2'd1;
            side_e.t1   = '{a: r_e_base, b: d_i, c: c_i};
        end
    end

    // divide cells: texture phases round(65536*seg/S) and round(32768*ring/R)
    usph_pkg::t_side     side_d [ND+1];
    usph_pkg::t_div_lane du     [ND+1];
    usph_pkg::t_div_lane dv     [ND+1];
    logic [11:0]         div_u;
    logic [11:0]         div_v;

    assign div_u     = {seg_c, 1'b0};
    assign div_v     = {ring_c, 1'b0};
    assign side_d[0] = side_e;
    assign du[0]     = '{rem: r_e_nu[27:16], w: r_e_nu[15:0]};
    assign dv[0]     = '{rem: r_e_nv[27:16], w: r_e_nv[15:0]};

    for (genvar g = 0; g < ND; g++) begin : g_div
        usph_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_du   (div_u),
            .i_dv   (div_v),
            .i_side (side_d[g]),
            .i_u    (du[g]),
            .i_v    (dv[g]),
            .o_side (side_d[g+1]),
            .o_u    (du[g+1]),
            .o_v    (dv[g+1])
        );
    end

    // fold each phase into a half turn around zero
    function automatic usph_pkg::t_cord_lane fold(input logic [15:0] t);
        usph_pkg::t_cord_lane l;
        logic signed [CW-1:0] z;
        z     = CW'(signed'({t, 16'd0}));
        l.x   = usph_pkg::CORDIC_X0;
        l.y   = '0;
        l.neg = 1'b0;
        if (z >= (CW'(1) <<< 30)) begin
            l.z   = z - (CW'(1) <<< 31);
            l.neg = 1'b1;
        end else if (z < -(CW'(1) <<< 30)) begin
            l.z   = z + (CW'(1) <<< 31);
            l.neg = 1'b1;
        end else begin
            l.z = z;
        end
        return l;
    endfunction

    // rotation cells
    usph_pkg::t_side      side_c [NS+1];
    usph_pkg::t_cord_lane cu     [NS+1];
    usph_pkg::t_cord_lane cv     [NS+1];

    always_comb begin
        side_c[0]    = side_d[ND];
        side_c[0].tu = du[ND].w;
        side_c[0].tv = dv[ND].w;
        cu[0]        = fold(du[ND].w);
        cv[0]        = fold(dv[ND].w);
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        usph_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(5'(g)),
            .i_side (side_c[g]),
            .i_u    (cu[g]),
            .i_v    (cv[g]),
            .o_side (side_c[g+1]),
            .o_u    (cu[g+1]),
            .o_v    (cv[g+1])
        );
    end

    // multiply stage
    logic signed [CW-1:0] cos_u;
    logic signed [CW-1:0] sin_u;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
    logic signed [31:0]   cu32;
    logic signed [31:0]   su32;
    logic signed [31:0]   sv32;
    usph_pkg::t_side      r_m_side;
    logic signed [63:0]   r_m_px;
    logic signed [63:0]   r_m_pz;
    logic signed [CW-1:0] r_m_cv;

    always_comb begin
        cos_u = cu[NS].neg ? -cu[NS].x : cu[NS].x;
        sin_u = cu[NS].neg ? -cu[NS].y : cu[NS].y;
        cos_v = cv[NS].neg ? -cv[NS].x : cv[NS].x;
        sin_v = cv[NS].neg ? -cv[NS].y : cv[NS].y;
        cu32  = signed'(cos_u[31:0]);
        su32  = signed'(sin_u[31:0]);
        sv32  = signed'(sin_v[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_side.valid <= 1'b0;
        end else begin
            r_m_side <= side_c[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_px <= sv32 * cu32;
        r_m_pz <= sv32 * su32;
        r_m_cv <= cos_v;
    end

    // round half up and saturate to one
    function automatic logic signed [15:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< usph_pkg::FRAC_BITS;
        if (v > lim) begin
            return 16'(lim);
        end else if (v < -lim) begin
            return 16'(-lim);
        end else begin
            return 16'(v);
        end
    endfunction

    usph_pkg::t_item n_item;
    usph_pkg::t_item r_item;
    logic            r_item_valid;

    always_comb begin
        n_item.reject  = r_m_side.reject;
        n_item.has_vtx = r_m_side.has_vtx;
        n_item.ntri    = r_m_side.ntri;
        n_item.vidx    = r_m_side.vidx;
        n_item.tu      = r_m_side.tu;
        n_item.tv      = r_m_side.tv;
        n_item.t1      = r_m_side.t1;
        n_item.t2      = r_m_side.t2;
        n_item.px      = sat_coord((r_m_px + (64'sd1 <<< (PSH - 1))) >>> PSH);
        n_item.pz      = sat_coord((r_m_pz + (64'sd1 <<< (PSH - 1))) >>> PSH);
        n_item.py      = sat_coord(64'((r_m_cv + (CW'(1) <<< (YSH - 1))) >>> YSH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= r_m_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    // result queue and serializer
    usph_pkg::t_result res;

    usph_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_push  (r_item_valid),
        .i_item  (r_item),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_kind         = res.kind;
    assign o_last_of_item = res.last;
    assign o_vertex_index = res.vidx;
    assign o_pos_x        = res.px;
    assign o_pos_y        = res.py;
    assign o_pos_z        = res.pz;
    assign o_tex_u        = res.tu;
    assign o_tex_v        = res.tv;
    assign o_corner_a     = res.ca;
    assign o_corner_b     = res.cb;
    assign o_corner_c     = res.cc;
endmodule
`default_nettype wire

// ===== tb/sv/uv_sphere_checker.sv =====
`timescale 1ns / 1ps
module uv_sphere_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [10:0] i_ring,
    input  wire logic [9:0]  i_segment,
    input  wire logic        o_valid,
    input  wire logic [1:0]  o_kind,
    input  wire logic        o_last_of_item,
    input  wire logic [19:0] o_vertex_index,
    input  wire logic [15:0] o_pos_x,
    input  wire logic [15:0] o_pos_y,
    input  wire logic [15:0] o_pos_z,
    input  wire logic [15:0] o_tex_u,
    input  wire logic [15:0] o_tex_v,
    input  wire logic [19:0] o_corner_a,
    input  wire logic [19:0] o_corner_b,
    input  wire logic [19:0] o_corner_c,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_pending,
    output int               o_fail_count
);

    // arctangent of 2^-k on a 2^32 full turn
    localparam logic [31:0] ARC_TAB [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic [10:0]       seg_count;
    logic [10:0]       ring_count;
    usph_pkg::t_result mesh_words [$];
    int                fail_count;

    assign o_pending    = mesh_words.size();
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // append one expected word at the tail
    task automatic queue_word(input usph_pkg::t_result w);
        mesh_words = {mesh_words, w};
    endtask

    // rotation-mode cordic, values in q2.30
    function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                    output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'($signed(phase));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1;
        end
        for (int k = 0; k < usph_pkg::CORDIC_STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ARC_TAB[k]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ARC_TAB[k]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] to_coord(input longint v, input int sh);
        longint r;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic usph_pkg::t_result tri_word(input longint a, input longint b,
                                                   input longint c);
        usph_pkg::t_result w;
        w = '0;
        w.kind = usph_pkg::KIND_TRI;
        w.ca = a[19:0];
        w.cb = b[19:0];
        w.cc = c[19:0];
        return w;
    endfunction

    // expected words for one grid position
    task automatic predict_mesh(input logic [10:0] rg, input logic [9:0] sg);
        longint nseg, nring, r, s, nxt, south, base, prev, tu, tv, cu, su, cv, sv;
        usph_pkg::t_result w;
        nseg  = seg_count < 3 ? 3 :
                (seg_count > usph_pkg::MAX_SEGMENTS ? usph_pkg::MAX_SEGMENTS : seg_count);
        nring = ring_count < 2 ? 2 :
                (ring_count > usph_pkg::MAX_RINGS ? usph_pkg::MAX_RINGS : ring_count);
        r = rg;
        s = sg;
        w = '0;
        if (r > nring || s >= nseg || (r == 0 && s != 0)) begin
            w.kind = usph_pkg::KIND_REJECT;
            w.last = 1'b1;
            queue_word(w);
            return;
        end
        nxt   = (s + 1 == nseg) ? 0 : s + 1;
        south = 1 + (nring - 1) * nseg;
        if (!(r == nring && s != 0)) begin
            tu = (2 * s * 65536 + nseg) / (2 * nseg);
            tv = (2 * r * 32768 + nring) / (2 * nring);
            sin_cos({tu[15:0], 16'h0000}, cu, su);
            sin_cos({tv[15:0], 16'h0000}, cv, sv);
            w.kind = usph_pkg::KIND_VERTEX;
            if (r == 0) w.vidx = '0;
            else if (r == nring) w.vidx = south[19:0];
            else w.vidx = 20'(1 + (r - 1) * nseg + s);
            w.px = to_coord(sv * cu, 60 - usph_pkg::FRAC_BITS);
            w.py = to_coord(cv, 30 - usph_pkg::FRAC_BITS);
            w.pz = to_coord(sv * su, 60 - usph_pkg::FRAC_BITS);
            w.tu = tu[15:0];
            w.tv = tv[15:0];
            queue_word(w);
        end
        if (r == 1) begin
            queue_word(tri_word(0, 1 + s, 1 + nxt));
        end else if (r >= 2 && r < nring) begin
            base = 1 + (r - 1) * nseg;
            prev = base - nseg;
            queue_word(tri_word(base + s, base + nxt, prev + s));
            queue_word(tri_word(prev + s, prev + nxt, base + nxt));
        end else if (r == nring) begin
            prev = 1 + (nring - 2) * nseg;
            queue_word(tri_word(south, prev + s, prev + nxt));
        end
        mesh_words[$].last = 1'b1;
    endtask

    // compare one output word against the oldest expectation
    task automatic check_word();
        usph_pkg::t_result w;
        if (mesh_words.size() == 0) begin
            report_mismatch("output word with nothing expected");
            return;
        end
        w = mesh_words.pop_front();
        if (o_kind != w.kind)
            report_mismatch($sformatf("kind %0d exp %0d", o_kind, w.kind));
        if (o_last_of_item != w.last)
            report_mismatch($sformatf("last %0d exp %0d", o_last_of_item, w.last));
        if (o_vertex_index != w.vidx)
            report_mismatch($sformatf("vertex_index %0d exp %0d", o_vertex_index, w.vidx));
        if (o_pos_x != w.px)
            report_mismatch($sformatf("pos_x %0h exp %0h", o_pos_x, w.px));
        if (o_pos_y != w.py)
            report_mismatch($sformatf("pos_y %0h exp %0h", o_pos_y, w.py));
        if (o_pos_z != w.pz)
            report_mismatch($sformatf("pos_z %0h exp %0h", o_pos_z, w.pz));
        if (o_tex_u != w.tu)
            report_mismatch($sformatf("tex_u %0d exp %0d", o_tex_u, w.tu));
        if (o_tex_v != w.tv)
            report_mismatch($sformatf("tex_v %0d exp %0d", o_tex_v, w.tv));
        if (o_corner_a != w.ca)
            report_mismatch($sformatf("corner_a %0d exp %0d", o_corner_a, w.ca));
        if (o_corner_b != w.cb)
            report_mismatch($sformatf("corner_b %0d exp %0d", o_corner_b, w.cb));
        if (o_corner_c != w.cc)
            report_mismatch($sformatf("corner_c %0d exp %0d", o_corner_c, w.cc));
    endtask

    initial fail_count = 0;

    // watch register writes, accepted commands and output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_count  <= 11'd16;
            ring_count <= 11'd16;
            mesh_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == usph_pkg::REG_RINGS) ring_count <= pwdata[10:0];
                else seg_count <= pwdata[10:0];
            end
            if (o_valid) check_word();
            if (start && !busy) predict_mesh(i_ring, i_segment);
        end
    end

endmodule

// ===== tb/sv/uv_sphere_tessellator_tb.sv =====
`timescale 1ns / 1ps
module uv_sphere_tessellator_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [10:0] i_ring;
    logic [9:0]  i_segment;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic        o_last_of_item;
    logic [19:0] o_vertex_index;
    logic signed [15:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0] o_tex_u, o_tex_v;
    logic [19:0] o_corner_a, o_corner_b, o_corner_c;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          fail_count;
    int          cycles = 0;
    int          cur_segs = 16;
    int          cur_rings = 16;

    always #4 i_clk = ~i_clk;

    uv_sphere_tessellator DUT (.*);

    uv_sphere_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_ring, .i_segment,
        .o_valid, .o_kind, .o_last_of_item, .o_vertex_index,
        .o_pos_x, .o_pos_y, .o_pos_z, .o_tex_u, .o_tex_v,
        .o_corner_a, .o_corner_b, .o_corner_c,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("uv_sphere_tessellator_tb: errors");
            $finish;
        end
    end

    // hold a command until the block takes it
    task automatic send_word(input logic [10:0] rg, input logic [9:0] sg);
        start     <= 1'b1;
        i_ring    <= rg;
        i_segment <= sg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_gaps(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending and let the pipeline empty
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mesh(input int segs, input int rgs);
        reg_write(usph_pkg::REG_SEGMENTS, segs);
        reg_write(usph_pkg::REG_RINGS, rgs);
        cur_segs  = segs < 3 ? 3 :
                    (segs > usph_pkg::MAX_SEGMENTS ? usph_pkg::MAX_SEGMENTS : segs);
        cur_rings = rgs < 2 ? 2 :
                    (rgs > usph_pkg::MAX_RINGS ? usph_pkg::MAX_RINGS : rgs);
    endtask

    // mostly legal grid positions, some raw noise
    task automatic random_words(input int count, input int pct, input bit pause_mid);
        int rg;
        for (int n = 0; n < count; n++) begin
            idle_gaps(pct);
            if (pause_mid && n == count / 2) drain();
            if ($urandom_range(99) < 15) begin
                send_word(11'($urandom), 10'($urandom));
            end else begin
                rg = $urandom_range(cur_rings);
                if (rg == 0) send_word(0, 0);
                else send_word(rg, $urandom_range(cur_segs - 1));
            end
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_ring    <= '0;
        i_segment <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // poles, wrap segment, bands, south cap and rejects at reset sizes
        send_word(0, 0);
        send_word(0, 5);
        send_word(1, 0);
        send_word(1, 15);
        send_word(2, 7);
        send_word(15, 15);
        send_word(16, 0);
        send_word(16, 3);
        send_word(17, 0);
        send_word(4, 16);
        send_word(11'h7FF, 10'h3FF);
        drain();

        // smallest sphere, registers below range clamp up
        set_mesh(0, 1);
        send_word(0, 0);
        send_word(1, 2);
        send_word(2, 0);
        send_word(2, 1);
        send_word(3, 0);
        send_word(1, 3);
        drain();

        // largest sphere, registers above range clamp down
        set_mesh(2047, 2047);
        send_word(1023, 1023);
        send_word(1024, 0);
        send_word(1024, 1023);
        send_word(512, 1023);
        send_word(1025, 0);
        send_word(1, 1023);
        drain();

        // random phases at several sizes
        set_mesh(7, 5);
        random_words(60, 16, 1'b1);
        drain();
        set_mesh(1024, 1024);
        random_words(55, 63, 1'b0);
        drain();
        set_mesh(3 + $urandom_range(60), 2 + $urandom_range(60));
        random_words(55, 0, 1'b0);
        drain();

        if (fail_count == 0) begin
            $display("uv_sphere_tessellator_tb: clean");
        end else begin
            $display("uv_sphere_tessellator_tb: errors");
        end
        $finish;
    end

endmodule
